// File: rtl/lrc_pkg.sv
// shared types and constants of the lru result cache
package lrc_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned KeyBits = 32;

  typedef enum logic [1:0] {
    OpLookup  = 2'd0,
    OpDrop    = 2'd1,
    OpDropAll = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CellHold,
    CellCapture,
    CellTakePrev,
    CellTakeNext,
    CellClear
  } cell_op_e;

  typedef struct packed {
    logic               valid;
    logic               exists;
    logic [KeyBits-1:0] key;
  } entry_t;

endpackage

// File: rtl/lrc_cell.sv
// one cell of the recency-ordered entry chain
module lrc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrc_pkg::cell_op_e          op_i,
  input  logic [lrc_pkg::KeyBits-1:0] cmp_key_i,
  input  lrc_pkg::entry_t            prev_i,
  input  lrc_pkg::entry_t            next_i,
  output lrc_pkg::entry_t            entry_o,
  output logic                       match_o
);
  import lrc_pkg::*;

  logic               valid_q, valid_d;
  logic               exists_q, exists_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic               match_q, match_d;

  always_comb begin
    valid_d  = valid_q;
    exists_d = exists_q;
    key_d    = key_q;
    match_d  = match_q;
    case (op_i)
      CellCapture: begin
        match_d = valid_q && (key_q == cmp_key_i);
      end
      CellTakePrev: begin
        valid_d  = prev_i.valid;
        exists_d = prev_i.exists;
        key_d    = prev_i.key;
      end
      CellTakeNext: begin
        valid_d  = next_i.valid;
        exists_d = next_i.exists;
        key_d    = next_i.key;
      end
      CellClear: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    exists_q <= exists_d;
    key_q    <= key_d;
  end

  assign entry_o.valid  = valid_q;
  assign entry_o.exists = exists_q;
  assign entry_o.key    = key_q;
  assign match_o        = match_q;

endmodule

// File: rtl/lrc_prefix.sv
// inclusive prefix or across the cell chain, log-depth network
module lrc_prefix (
  input  logic [lrc_pkg::Entries-1:0] mark_i,
  output logic [lrc_pkg::Entries-1:0] any_o
);
  import lrc_pkg::*;

  localparam int unsigned Levels = (Entries > 1) ? $clog2(Entries) : 1;

  logic [Levels:0][Entries-1:0] lvl;

  assign lvl[0] = mark_i;

  for (genvar l = 0; l < Levels; l++) begin : g_level
    for (genvar i = 0; i < Entries; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign any_o = lvl[Levels];

endmodule

// File: rtl/lru_result_cache_core.sv
// lru result cache top level: command sequencer around a chain of entry cells
// a word accepted while idle passes the match, scan and apply steps; its result strobe is registered from apply
// a new word is taken only once the last one has finished the match, scan and apply steps of the chain
// busy_o is high during the work steps; start_i is taken again in the strobe cycle
// reset empties the cache at once: every cell valid bit clears, no clearing pass
// the receiver cannot stall: done_o is high for exactly one cycle per word
module lru_result_cache_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_i,
  input  logic        probe_exists_i,
  output logic        done_o,
  output logic        hit_o,
  output logic        exists_o,
  output logic        evicted_o
);
  import lrc_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StScan,
    StApply
  } state_e;

  state_e             state_q;
  op_e                op_q;
  logic [KeyBits-1:0] key_q;
  logic               probe_q;

  // scan results, registered for the apply step
  logic [Entries-1:0] thermo_q;
  logic               hit_q;
  logic               found_ex_q;
  logic               full_q;

  logic               done_q, hit_res_q, ex_res_q, ev_res_q;

  // chain wiring
  entry_t   cell_entry [Entries];
  logic     cell_match [Entries];
  cell_op_e cell_op    [Entries];
  entry_t   new_entry;
  entry_t   empty_entry;

  logic [Entries-1:0] match_vec, valid_vec, ex_vec, mark_vec, prefix_vec;

  logic accept;
  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  // word inserted at the head on a lookup: stored bit on a hit, probe bit on a miss
  assign new_entry.valid  = 1'b1;
  assign new_entry.exists = hit_q ? found_ex_q : probe_q;
  assign new_entry.key    = key_q;

  // shifted in at the tail when an entry is dropped
  assign empty_entry.valid  = 1'b0;
  assign empty_entry.exists = 1'b0;
  assign empty_entry.key    = '0;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    entry_t prev_in, next_in;
    if (i == 0) begin : g_head
      assign prev_in = new_entry;
    end else begin : g_mid
      assign prev_in = cell_entry[i-1];
    end
    if (i == Entries - 1) begin : g_tail
      assign next_in = empty_entry;
    end else begin : g_inner
      assign next_in = cell_entry[i+1];
    end

    lrc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (cell_op[i]),
      .cmp_key_i (key_q),
      .prev_i    (prev_in),
      .next_i    (next_in),
      .entry_o   (cell_entry[i]),
      .match_o   (cell_match[i])
    );

    assign match_vec[i] = cell_match[i];
    assign valid_vec[i] = cell_entry[i].valid;
    assign ex_vec[i]    = cell_entry[i].exists;

    // per-cell command for each step
    // lookup: head takes the new word, cells up to the stop point shift down
    // drop: cells from the matching one onward shift up toward the head
    always_comb begin
      cell_op[i] = CellHold;
      case (state_q)
        StMatch: cell_op[i] = CellCapture;
        StApply: begin
          case (op_q)
            OpLookup: begin
              if (i == 0) begin
                cell_op[i] = CellTakePrev;
              end else if (!thermo_q[(i == 0) ? 0 : i-1]) begin
                cell_op[i] = CellTakePrev;
              end
            end
            OpDrop: begin
              if (thermo_q[i]) begin
                cell_op[i] = CellTakeNext;
              end
            end
            OpDropAll: cell_op[i] = CellClear;
            default: cell_op[i] = CellHold;
          endcase
        end
        default: cell_op[i] = CellHold;
      endcase
    end
  end

  // stop point of the shift: the matching cell on a hit, the first free cell on
  // a lookup miss; with no free cell nothing marks and the tail falls off
  always_comb begin
    if ((op_q == OpLookup) && !(|match_vec)) begin
      mark_vec = ~valid_vec;
    end else begin
      mark_vec = match_vec;
    end
  end

  lrc_prefix u_prefix (
    .mark_i (mark_vec),
    .any_o  (prefix_vec)
  );

  // sequencer with registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      done_q    <= 1'b0;
      hit_res_q <= 1'b0;
      ex_res_q  <= 1'b0;
      ev_res_q  <= 1'b0;
    end else begin
      done_q <= (state_q == StApply);
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StMatch;
          end
        end
        StMatch: state_q <= StScan;
        StScan:  state_q <= StApply;
        StApply: begin
          state_q <= StIdle;
          case (op_q)
            OpLookup: begin
              hit_res_q <= hit_q;
              ex_res_q  <= hit_q ? found_ex_q : probe_q;
              ev_res_q  <= !hit_q && full_q;
            end
            OpDrop, OpDropAll: begin
              hit_res_q <= hit_q;
              ex_res_q  <= 1'b0;
              ev_res_q  <= 1'b0;
            end
            default: begin
              hit_res_q <= 1'b0;
              ex_res_q  <= 1'b0;
              ev_res_q  <= 1'b0;
            end
          endcase
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // command word and scan payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(opcode_i);
      key_q   <= key_i[KeyBits-1:0];
      probe_q <= probe_exists_i;
    end
    if (state_q == StScan) begin
      thermo_q   <= prefix_vec;
      hit_q      <= |match_vec;
      found_ex_q <= |(match_vec & ex_vec);
      full_q     <= valid_vec[Entries-1];
    end
  end

  assign done_o    = done_q;
  assign hit_o     = hit_res_q;
  assign exists_o  = ex_res_q;
  assign evicted_o = ev_res_q;

endmodule
